/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers included by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies consequence in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Condition implies consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/sgrcd_pkg.sv */
// ----------------------------------------------------------------------------
// sgrcd_pkg
// Types, codes and the xterm-256 palette helper for the SGR color decoder.
// ----------------------------------------------------------------------------
package sgrcd_pkg;

  typedef struct packed {
    logic [7:0]  param_value;
    logic        last_param;
    logic [15:0] text_row;
    logic [9:0]  text_col;
  } in_item_t;

  typedef struct packed {
    logic [15:0] stop_row;
    logic [9:0]  stop_col;
    logic        fore_set;
    logic [4:0]  fore_code;
    logic [31:0] fore_rgba;
    logic        back_set;
    logic [4:0]  back_code;
    logic [31:0] back_rgba;
  } out_item_t;

  typedef enum logic [1:0] {
    BoldUnset = 2'd0,
    BoldOff   = 2'd1,
    BoldOn    = 2'd2
  } bold_e;

  typedef enum logic [1:0] {
    TgtNone = 2'd0,
    TgtFore = 2'd1,
    TgtBack = 2'd2
  } tgt_e;

  // Color codes
  localparam logic [4:0] CodeDefault = 5'd16;
  localparam logic [4:0] CodeDirect  = 5'd17;
  localparam logic [4:0] CodeNone    = 5'd31;
  localparam logic [4:0] BoldShift   = 5'd8;
  localparam logic [4:0] BoldLimit   = 5'd8;

  // SGR parameter codes
  localparam logic [7:0] SgrReset      = 8'd0;
  localparam logic [7:0] SgrBold       = 8'd1;
  localparam logic [7:0] SgrBoldOff    = 8'd21;
  localparam logic [7:0] SgrNormal     = 8'd22;
  localparam logic [7:0] SgrForeBase   = 8'd30;
  localparam logic [7:0] SgrForeLast   = 8'd37;
  localparam logic [7:0] SgrForeExt    = 8'd38;
  localparam logic [7:0] SgrForeDflt   = 8'd39;
  localparam logic [7:0] SgrBackBase   = 8'd40;
  localparam logic [7:0] SgrBackLast   = 8'd47;
  localparam logic [7:0] SgrBackExt    = 8'd48;
  localparam logic [7:0] SgrBackDflt   = 8'd49;
  localparam logic [7:0] SgrBrFgBase   = 8'd90;
  localparam logic [7:0] SgrBrFgLast   = 8'd97;
  localparam logic [7:0] SgrBrBgBase   = 8'd100;
  localparam logic [7:0] SgrBrBgLast   = 8'd107;

  // Extended color modes and byte positions
  localparam logic [7:0] ExtModeDirect  = 8'd2;
  localparam logic [7:0] ExtModePalette = 8'd5;
  localparam logic [7:0] PosFirst       = 8'd0;
  localparam logic [7:0] PosMode        = 8'd1;
  localparam logic [7:0] PosRed         = 8'd2;
  localparam logic [7:0] PosGreen       = 8'd3;
  localparam logic [7:0] PosBlue        = 8'd4;
  localparam logic [7:0] PosMax         = 8'd255;

  // Palette layout
  localparam logic [7:0] CubeBase  = 8'h10;
  localparam logic [7:0] CubeLast  = 8'hE7;
  localparam logic [7:0] GrayBase  = 8'hE8;
  localparam logic [7:0] CubeStep  = 8'(255 / 5);
  localparam logic [7:0] GrayStep  = 8'(255 / 23);
  localparam logic [7:0] CubePlane = 8'd36;
  localparam logic [7:0] CubeRow   = 8'd6;
  localparam logic [7:0] AlphaOpaque = 8'hFF;

  // RGB of palette entries 16-255 (cube and gray ramp).
  function automatic logic [23:0] xterm_rgb(logic [7:0] n);
    logic [7:0] k;
    logic [7:0] rem;
    logic [2:0] r;
    logic [2:0] g;
    logic [2:0] b;
    logic [7:0] y;
    k   = n - CubeBase;
    r   = 3'(k >= CubePlane) + 3'(k >= 8'd72) + 3'(k >= 8'd108)
        + 3'(k >= 8'd144) + 3'(k >= 8'd180);
    rem = k - 8'(r) * CubePlane;
    g   = 3'(rem >= CubeRow) + 3'(rem >= 8'd12) + 3'(rem >= 8'd18)
        + 3'(rem >= 8'd24) + 3'(rem >= 8'd30);
    b   = 3'(rem - 8'(g) * CubeRow);
    y   = (n - GrayBase) * GrayStep;
    if (n <= CubeLast) begin
      return {8'(r) * CubeStep, 8'(g) * CubeStep, 8'(b) * CubeStep};
    end else begin
      return {y, y, y};
    end
  endfunction

endpackage

/* hdl/ansi_sgr_color_decoder.sv */
// ----------------------------------------------------------------------------
// ansi_sgr_color_decoder
// Decodes the parameter bytes of one SGR escape sequence into color stops.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) takes one SGR
//   parameter byte per item, with the row and column of the sequence and a
//   flag on the final byte. Output channel (out_valid_o / out_stall_i /
//   out_item_o) carries at most one color stop per sequence, produced by
//   the final byte when a fore or back color was set and the sequence is
//   well formed.
//   Results are registered in the output or skid register. Throughput:
//   one item per cycle while in_stall_o is low; decode is a single pass of
//   compare and small constant-multiply logic into state and result registers.
//   Stall: an output register plus a one-entry skid register hold results;
//   in_stall_o rises only while the skid register is full, i.e. after the
//   receiver has held off two pending results.
//   Reset: clears the sequence state and both output slots; the block is
//   ready as soon as reset is released.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ansi_sgr_color_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sgrcd_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sgrcd_pkg::out_item_t out_item_o
);

  logic                   accept;
  logic [7:0]             v;
  logic [7:0]             pos_q, pos_d;
  sgrcd_pkg::bold_e       bold_q, bold_d;
  logic [4:0]             pfore_q, pfore_d;
  logic [4:0]             pback_q, pback_d;
  sgrcd_pkg::tgt_e        tgt_q, tgt_d;
  logic                   mode5_q, mode5_d;
  logic [7:0]             red_q, red_d;
  logic [7:0]             green_q, green_d;
  logic                   aborted_q, aborted_d;

  logic                   fin_ok;
  logic                   abort_fin;
  logic [4:0]             ext_code;
  logic [31:0]            ext_rgba;
  logic [4:0]             fcode;
  logic [4:0]             bcode;
  logic                   emit;
  sgrcd_pkg::out_item_t   res;

  logic                   out_valid_q;
  sgrcd_pkg::out_item_t   out_q;
  logic                   skid_valid_q;
  sgrcd_pkg::out_item_t   skid_q;
  logic                   out_free;

  assign in_stall_o  = skid_valid_q;
  assign accept      = in_valid_i & ~skid_valid_q;
  assign v           = in_item_i.param_value;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign out_free    = ~out_valid_q | ~out_stall_i;

  // Per-byte decode
  always_comb begin
    pos_d     = pos_q;
    bold_d    = bold_q;
    pfore_d   = pfore_q;
    pback_d   = pback_q;
    tgt_d     = tgt_q;
    mode5_d   = mode5_q;
    red_d     = red_q;
    green_d   = green_q;
    aborted_d = aborted_q;

    if (!aborted_q) begin
      if (tgt_q != sgrcd_pkg::TgtNone) begin
        if (pos_q == sgrcd_pkg::PosMode) begin
          mode5_d = (v == sgrcd_pkg::ExtModePalette);
          if (v != sgrcd_pkg::ExtModeDirect && v != sgrcd_pkg::ExtModePalette) begin
            aborted_d = 1'b1;
          end
        end else if (pos_q == sgrcd_pkg::PosRed) begin
          red_d = v;
        end else if (pos_q == sgrcd_pkg::PosGreen) begin
          green_d = v;
        end else if (pos_q != sgrcd_pkg::PosBlue) begin
          aborted_d = 1'b1;
        end
      end else if (v == sgrcd_pkg::SgrForeExt || v == sgrcd_pkg::SgrBackExt) begin
        if (pos_q == sgrcd_pkg::PosFirst) begin
          tgt_d = (v == sgrcd_pkg::SgrForeExt) ? sgrcd_pkg::TgtFore : sgrcd_pkg::TgtBack;
        end else begin
          aborted_d = 1'b1;
        end
      end else if (v == sgrcd_pkg::SgrReset) begin
        bold_d  = sgrcd_pkg::BoldOff;
        pfore_d = sgrcd_pkg::CodeDefault;
        pback_d = sgrcd_pkg::CodeDefault;
      end else if (v == sgrcd_pkg::SgrBold) begin
        bold_d = sgrcd_pkg::BoldOn;
      end else if (v == sgrcd_pkg::SgrBoldOff || v == sgrcd_pkg::SgrNormal) begin
        bold_d = sgrcd_pkg::BoldOff;
      end else if (v == sgrcd_pkg::SgrForeDflt) begin
        pfore_d = sgrcd_pkg::CodeDefault;
      end else if (v == sgrcd_pkg::SgrBackDflt) begin
        pback_d = sgrcd_pkg::CodeDefault;
      end else if (v inside {[sgrcd_pkg::SgrForeBase:sgrcd_pkg::SgrForeLast]}) begin
        pfore_d = 5'(v - sgrcd_pkg::SgrForeBase);
      end else if (v inside {[sgrcd_pkg::SgrBackBase:sgrcd_pkg::SgrBackLast]}) begin
        pback_d = 5'(v - sgrcd_pkg::SgrBackBase);
      end else if (v inside {[sgrcd_pkg::SgrBrFgBase:sgrcd_pkg::SgrBrFgLast]}) begin
        pfore_d = 5'(v - sgrcd_pkg::SgrBrFgBase) + sgrcd_pkg::BoldShift;
      end else if (v inside {[sgrcd_pkg::SgrBrBgBase:sgrcd_pkg::SgrBrBgLast]}) begin
        pback_d = 5'(v - sgrcd_pkg::SgrBrBgBase) + sgrcd_pkg::BoldShift;
      end
    end

    if (pos_q != sgrcd_pkg::PosMax) begin
      pos_d = pos_q + 8'd1;
    end
  end

  // Final-byte resolution; the closing color byte is taken from the input.
  always_comb begin
    fin_ok = (mode5_q && pos_q == sgrcd_pkg::PosRed)
           || (!mode5_q && pos_q == sgrcd_pkg::PosBlue);
    if (mode5_q && v < sgrcd_pkg::CubeBase) begin
      ext_code = v[4:0];
      ext_rgba = '0;
    end else if (mode5_q) begin
      ext_code = sgrcd_pkg::CodeDirect;
      ext_rgba = {sgrcd_pkg::xterm_rgb(v), sgrcd_pkg::AlphaOpaque};
    end else begin
      ext_code = sgrcd_pkg::CodeDirect;
      ext_rgba = {red_q, green_q, v, sgrcd_pkg::AlphaOpaque};
    end

    abort_fin = aborted_q;
    fcode     = pfore_q;
    bcode     = pback_q;
    if (!aborted_q) begin
      if (tgt_q != sgrcd_pkg::TgtNone) begin
        if (pos_q == sgrcd_pkg::PosMode
            && v != sgrcd_pkg::ExtModeDirect && v != sgrcd_pkg::ExtModePalette) begin
          abort_fin = 1'b1;
        end else if (!fin_ok) begin
          abort_fin = 1'b1;
        end else if (tgt_q == sgrcd_pkg::TgtFore) begin
          fcode = ext_code;
        end else begin
          bcode = ext_code;
        end
      end else if (v == sgrcd_pkg::SgrForeExt || v == sgrcd_pkg::SgrBackExt) begin
        abort_fin = 1'b1;
      end else begin
        fcode = pfore_d;
        bcode = pback_d;
        if (fcode < sgrcd_pkg::BoldLimit && bold_d == sgrcd_pkg::BoldOn) begin
          fcode = fcode + sgrcd_pkg::BoldShift;
        end
      end
    end

    emit = in_item_i.last_param && !abort_fin
         && (fcode != sgrcd_pkg::CodeNone || bcode != sgrcd_pkg::CodeNone);

    res.stop_row  = in_item_i.text_row;
    res.stop_col  = in_item_i.text_col;
    res.fore_set  = (fcode != sgrcd_pkg::CodeNone);
    res.fore_code = res.fore_set ? fcode : 5'd0;
    res.fore_rgba = (fcode == sgrcd_pkg::CodeDirect) ? ext_rgba : 32'd0;
    res.back_set  = (bcode != sgrcd_pkg::CodeNone);
    res.back_code = res.back_set ? bcode : 5'd0;
    res.back_rgba = (bcode == sgrcd_pkg::CodeDirect) ? ext_rgba : 32'd0;
  end

  // The final byte of a sequence returns the state to its reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      bold_q    <= sgrcd_pkg::BoldUnset;
      pfore_q   <= sgrcd_pkg::CodeNone;
      pback_q   <= sgrcd_pkg::CodeNone;
      tgt_q     <= sgrcd_pkg::TgtNone;
      mode5_q   <= 1'b0;
      aborted_q <= 1'b0;
    end else if (accept && in_item_i.last_param) begin
      pos_q     <= '0;
      bold_q    <= sgrcd_pkg::BoldUnset;
      pfore_q   <= sgrcd_pkg::CodeNone;
      pback_q   <= sgrcd_pkg::CodeNone;
      tgt_q     <= sgrcd_pkg::TgtNone;
      mode5_q   <= 1'b0;
      aborted_q <= 1'b0;
    end else if (accept) begin
      pos_q     <= pos_d;
      bold_q    <= bold_d;
      pfore_q   <= pfore_d;
      pback_q   <= pback_d;
      tgt_q     <= tgt_d;
      mode5_q   <= mode5_d;
      aborted_q <= aborted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      red_q   <= red_d;
      green_q <= green_d;
    end
  end

  // Output register and skid slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q | (accept & emit);
      skid_valid_q <= 1'b0;
    end else if (accept && emit) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (accept && emit) begin
      skid_q <= res;
    end
  end

  `ASSERT_SAME(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  `ASSERT_NEXT(a_last_clears, clk_i, rst_ni, accept && in_item_i.last_param,
               pos_q == '0 && !aborted_q && tgt_q == sgrcd_pkg::TgtNone)
  `ASSERT_SAME(a_ext_after_first, clk_i, rst_ni, tgt_q != sgrcd_pkg::TgtNone,
               pos_q != sgrcd_pkg::PosFirst)
  `ASSERT_SAME(a_result_has_color, clk_i, rst_ni, out_valid_q,
               out_q.fore_set || out_q.back_set)

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives SGR parameter sequences into ansi_sgr_color_decoder and compares
// every color stop it emits with a cycle-free model of the decoder kept in a
// scoreboard. Sequences are plain codes, palette and direct extended colors,
// broken extended forms, random noise and one very long sequence; both
// channels idle at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CycleLimit = 400000;
  localparam int ItemTarget = 2000;

  class stop_board;
    sgrcd_pkg::out_item_t stops_due[$];
    int                   errors;
    logic [7:0]           seq_pos;
    sgrcd_pkg::bold_e     bold;
    logic [4:0]           fore_pend;
    logic [4:0]           back_pend;
    sgrcd_pkg::tgt_e      ext_tgt;
    logic [7:0]           ext_mode;
    logic [7:0]           ext_byte[3];
    logic                 aborted;
    logic [31:0]          fore_hold;
    logic [31:0]          back_hold;

    function new();
      errors = 0;
      clear_seq();
    endfunction

    function void clear_seq();
      seq_pos   = '0;
      bold      = sgrcd_pkg::BoldUnset;
      fore_pend = sgrcd_pkg::CodeNone;
      back_pend = sgrcd_pkg::CodeNone;
      ext_tgt   = sgrcd_pkg::TgtNone;
      ext_mode  = '0;
      ext_byte[0] = '0;
      ext_byte[1] = '0;
      ext_byte[2] = '0;
      aborted   = 1'b0;
      fore_hold = '0;
      back_hold = '0;
    endfunction

    function void apply_code(logic [7:0] v);
      if (v == sgrcd_pkg::SgrReset) begin
        bold      = sgrcd_pkg::BoldOff;
        fore_pend = sgrcd_pkg::CodeDefault;
        back_pend = sgrcd_pkg::CodeDefault;
      end else if (v == sgrcd_pkg::SgrBold) begin
        bold = sgrcd_pkg::BoldOn;
      end else if (v == sgrcd_pkg::SgrBoldOff || v == sgrcd_pkg::SgrNormal) begin
        bold = sgrcd_pkg::BoldOff;
      end else if (v == sgrcd_pkg::SgrForeDflt) begin
        fore_pend = sgrcd_pkg::CodeDefault;
      end else if (v == sgrcd_pkg::SgrBackDflt) begin
        back_pend = sgrcd_pkg::CodeDefault;
      end else if (v >= sgrcd_pkg::SgrForeBase && v <= sgrcd_pkg::SgrForeLast) begin
        fore_pend = 5'(v - sgrcd_pkg::SgrForeBase);
      end else if (v >= sgrcd_pkg::SgrBackBase && v <= sgrcd_pkg::SgrBackLast) begin
        back_pend = 5'(v - sgrcd_pkg::SgrBackBase);
      end else if (v >= sgrcd_pkg::SgrBrFgBase && v <= sgrcd_pkg::SgrBrFgLast) begin
        fore_pend = 5'(v - sgrcd_pkg::SgrBrFgBase) + sgrcd_pkg::BoldShift;
      end else if (v >= sgrcd_pkg::SgrBrBgBase && v <= sgrcd_pkg::SgrBrBgLast) begin
        back_pend = 5'(v - sgrcd_pkg::SgrBrBgBase) + sgrcd_pkg::BoldShift;
      end
    endfunction

    // Resolves a finished extended color; 0 when the form is malformed.
    function bit resolve_ext(output logic [4:0] code, output logic [31:0] rgba);
      int n;
      int k;
      int y;
      int step;
      code = sgrcd_pkg::CodeDirect;
      rgba = '0;
      if (ext_mode == sgrcd_pkg::ExtModeDirect && seq_pos == sgrcd_pkg::PosBlue) begin
        rgba = {ext_byte[0], ext_byte[1], ext_byte[2], sgrcd_pkg::AlphaOpaque};
        return 1'b1;
      end
      if (ext_mode == sgrcd_pkg::ExtModePalette && seq_pos == sgrcd_pkg::PosRed) begin
        n = int'(ext_byte[0]);
        if (n < int'(sgrcd_pkg::CubeBase)) begin
          code = 5'(n);
        end else if (n <= int'(sgrcd_pkg::CubeLast)) begin
          k = n - int'(sgrcd_pkg::CubeBase);
          step = int'(sgrcd_pkg::CubeStep);
          rgba = {8'(step * (k / 36)), 8'(step * ((k % 36) / 6)),
                  8'(step * (k % 6)), sgrcd_pkg::AlphaOpaque};
        end else begin
          y = int'(sgrcd_pkg::GrayStep) * (n - int'(sgrcd_pkg::GrayBase));
          rgba = {8'(y), 8'(y), 8'(y), sgrcd_pkg::AlphaOpaque};
        end
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_param(sgrcd_pkg::in_item_t it);
      logic [7:0]           v;
      logic [4:0]           code;
      logic [31:0]          rgba;
      logic [4:0]           fc;
      sgrcd_pkg::out_item_t want;
      v = it.param_value;
      if (!aborted) begin
        if (ext_tgt != sgrcd_pkg::TgtNone) begin
          if (seq_pos == sgrcd_pkg::PosMode) begin
            ext_mode = v;
            if (v != sgrcd_pkg::ExtModeDirect && v != sgrcd_pkg::ExtModePalette) begin
              aborted = 1'b1;
            end
          end else if (seq_pos >= sgrcd_pkg::PosRed && seq_pos <= sgrcd_pkg::PosBlue) begin
            ext_byte[2'(seq_pos - sgrcd_pkg::PosRed)] = v;
          end else begin
            aborted = 1'b1;
          end
        end else if (v == sgrcd_pkg::SgrForeExt || v == sgrcd_pkg::SgrBackExt) begin
          if (seq_pos == sgrcd_pkg::PosFirst) begin
            ext_tgt = (v == sgrcd_pkg::SgrForeExt) ? sgrcd_pkg::TgtFore : sgrcd_pkg::TgtBack;
          end else begin
            aborted = 1'b1;
          end
        end else begin
          apply_code(v);
        end
      end
      if (!it.last_param) begin
        if (seq_pos != sgrcd_pkg::PosMax) seq_pos++;
        return;
      end
      if (!aborted && ext_tgt != sgrcd_pkg::TgtNone) begin
        if (resolve_ext(code, rgba)) begin
          if (ext_tgt == sgrcd_pkg::TgtFore) begin
            fore_pend = code;
            fore_hold = rgba;
          end else begin
            back_pend = code;
            back_hold = rgba;
          end
        end else begin
          aborted = 1'b1;
        end
      end
      if (aborted || (fore_pend == sgrcd_pkg::CodeNone && back_pend == sgrcd_pkg::CodeNone)) begin
        clear_seq();
        return;
      end
      fc = fore_pend;
      if (fc != sgrcd_pkg::CodeNone && fc < sgrcd_pkg::BoldLimit
          && bold == sgrcd_pkg::BoldOn) begin
        fc = fc + sgrcd_pkg::BoldShift;
      end
      want.stop_row  = it.text_row;
      want.stop_col  = it.text_col;
      want.fore_set  = (fc != sgrcd_pkg::CodeNone);
      want.fore_code = (fc != sgrcd_pkg::CodeNone) ? fc : '0;
      want.fore_rgba = (fc == sgrcd_pkg::CodeDirect) ? fore_hold : '0;
      want.back_set  = (back_pend != sgrcd_pkg::CodeNone);
      want.back_code = (back_pend != sgrcd_pkg::CodeNone) ? back_pend : '0;
      want.back_rgba = (back_pend == sgrcd_pkg::CodeDirect) ? back_hold : '0;
      stops_due = {stops_due, want};
      clear_seq();
    endfunction

    function void check_stop(sgrcd_pkg::out_item_t got);
      sgrcd_pkg::out_item_t want;
      if (stops_due.size() == 0) begin
        $display("%0t: unexpected stop, expected none actual %0h", $time, got);
        errors++;
        return;
      end
      want = stops_due.pop_front();
      if (want !== got) begin
        $display("%0t: stop mismatch, expected %0h actual %0h", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  sgrcd_pkg::in_item_t  in_item_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  sgrcd_pkg::out_item_t out_item_o;

  stop_board  sb;
  logic [7:0] seq_bytes[$];
  int         items_sent;
  int         cycles;
  bit         calm;

  ansi_sgr_color_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 9);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_param(in_item_i);
      if (out_valid_o && !out_stall_i) sb.check_stop(out_item_o);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic drive_item(sgrcd_pkg::in_item_t it);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic send_seq();
    sgrcd_pkg::in_item_t it;
    foreach (seq_bytes[i]) begin
      it.param_value = seq_bytes[i];
      it.last_param  = (i == seq_bytes.size() - 1);
      it.text_row    = 16'($urandom_range(65535));
      it.text_col    = 10'($urandom_range(1023));
      drive_item(it);
    end
  endtask

  function automatic logic [7:0] pick_code();
    case ($urandom_range(9))
      0: return sgrcd_pkg::SgrReset;
      1: return sgrcd_pkg::SgrBold;
      2: return $urandom_range(1) ? sgrcd_pkg::SgrBoldOff : sgrcd_pkg::SgrNormal;
      3: return sgrcd_pkg::SgrForeBase + 8'($urandom_range(7));
      4: return sgrcd_pkg::SgrForeDflt;
      5: return sgrcd_pkg::SgrBackBase + 8'($urandom_range(7));
      6: return sgrcd_pkg::SgrBackDflt;
      7: return sgrcd_pkg::SgrBrFgBase + 8'($urandom_range(7));
      8: return sgrcd_pkg::SgrBrBgBase + 8'($urandom_range(7));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] pick_ext();
    return $urandom_range(1) ? sgrcd_pkg::SgrForeExt : sgrcd_pkg::SgrBackExt;
  endfunction

  task automatic random_seq();
    int kind;
    int len;
    kind = $urandom_range(99);
    seq_bytes = {};
    if (kind < 40) begin
      len = $urandom_range(1, 5);
      repeat (len) seq_bytes = {seq_bytes, pick_code()};
    end else if (kind < 58) begin
      seq_bytes = {pick_ext(), sgrcd_pkg::ExtModePalette, 8'($urandom_range(255))};
    end else if (kind < 74) begin
      seq_bytes = {pick_ext(), sgrcd_pkg::ExtModeDirect, 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255))};
    end else if (kind < 84) begin
      // extended form with random mode and length: may be well formed or broken
      len = $urandom_range(1, 7);
      seq_bytes = {seq_bytes, pick_ext()};
      case ($urandom_range(2))
        0: seq_bytes = {seq_bytes, sgrcd_pkg::ExtModePalette};
        1: seq_bytes = {seq_bytes, sgrcd_pkg::ExtModeDirect};
        default: seq_bytes = {seq_bytes, 8'($urandom_range(255))};
      endcase
      repeat (len - 1) seq_bytes = {seq_bytes, 8'($urandom_range(255))};
    end else if (kind < 92) begin
      // extended code after a plain code
      seq_bytes = {seq_bytes, pick_code()};
      seq_bytes = {seq_bytes, pick_ext()};
      len = $urandom_range(0, 4);
      repeat (len) seq_bytes = {seq_bytes, 8'($urandom_range(255))};
    end else begin
      len = $urandom_range(1, 8);
      repeat (len) seq_bytes = {seq_bytes, 8'($urandom_range(255))};
    end
    send_seq();
  endtask

  task automatic long_seq();
    seq_bytes = {};
    repeat (256 + $urandom_range(40)) seq_bytes = {seq_bytes, pick_code()};
    send_seq();
  endtask

  initial begin
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    rst_ni      <= 1'b0;
    items_sent = 0;
    cycles     = 0;
    calm       = 1'b0;
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    seq_bytes = {sgrcd_pkg::SgrReset};
    send_seq();
    seq_bytes = {sgrcd_pkg::SgrBold, sgrcd_pkg::SgrForeBase + 8'd1};
    send_seq();
    // bold alone emits nothing
    seq_bytes = {sgrcd_pkg::SgrBold};
    send_seq();
    seq_bytes = {sgrcd_pkg::SgrForeExt, sgrcd_pkg::ExtModePalette, 8'd255};
    send_seq();
    seq_bytes = {sgrcd_pkg::SgrBackExt, sgrcd_pkg::ExtModeDirect, 8'd255, 8'd0, 8'd128};
    send_seq();
    seq_bytes = {sgrcd_pkg::SgrForeBase + 8'd1, sgrcd_pkg::SgrForeExt,
                 sgrcd_pkg::ExtModePalette, 8'd1};
    send_seq();
    seq_bytes = {sgrcd_pkg::SgrBackExt, 8'd3};
    send_seq();
    seq_bytes = {sgrcd_pkg::SgrForeExt, sgrcd_pkg::ExtModePalette, 8'd7, 8'd9};
    send_seq();
    seq_bytes = {sgrcd_pkg::SgrForeExt, sgrcd_pkg::ExtModeDirect, 8'd1};
    send_seq();

    while (items_sent < ItemTarget) begin
      calm = (items_sent >= 1300 && items_sent < 1600);
      if (items_sent >= 1000 && items_sent < 1010) long_seq();
      else random_seq();
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);

    while (sb.stops_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
